// ===== rtl/core/srm_pkg.sv =====
package srm_pkg;

    // mailbox bank geometry
    localparam int SLOTS        = 16;
    localparam int BOXES        = 8;
    localparam int PAYLOAD_BITS = 32;

    localparam int IDX_W     = $clog2(SLOTS);
    localparam int BOX_IDX_W = (BOXES > 1) ? $clog2(BOXES) : 1;
    localparam int ADDR_W    = (BOXES * SLOTS > 1) ? $clog2(BOXES * SLOTS) : 1;
    localparam int SRC_W     = 8;
    localparam int BOX_W     = 3;
    localparam int BODY_W    = 32;

    localparam logic [SRC_W-1:0] HW_SOURCE_RESET = 8'hFF;

    // operation codes
    localparam logic FUNC_SEND = 1'b0;
    localparam logic FUNC_RECV = 1'b1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        ST_SENT = 2'd0,
        ST_FULL = 2'd1,
        ST_GOT  = 2'd2,
        ST_NONE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEND,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              func;
        logic [BOX_W-1:0]  box;
        logic [SRC_W-1:0]  source_id;
        logic              any_source;
        logic              from_hw;
        logic [BODY_W-1:0] payload;
    } in_t;

    typedef struct packed {
        status_t           status;
        logic [SRC_W-1:0]  msg_source;
        logic [BODY_W-1:0] msg_payload;
    } out_t;

    typedef struct packed {
        logic [SRC_W-1:0]        src;
        logic [PAYLOAD_BITS-1:0] body;
    } slot_t;

    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        slot_t wr_data;
    } ram_req_t;

    function automatic idx_t ring_next(idx_t i);
        idx_t r;
        if (int'(i) == SLOTS - 1)
            r = '0;
        else
            r = i + idx_t'(1);
        return r;
    endfunction

    function automatic idx_t ring_prev(idx_t i);
        idx_t r;
        if (i == '0)
            r = idx_t'(SLOTS - 1);
        else
            r = i - idx_t'(1);
        return r;
    endfunction

    function automatic addr_t slot_addr(logic [BOX_W-1:0] box, idx_t i);
        logic [ADDR_W+BOX_W-1:0] a;
        a = (ADDR_W+BOX_W)'(box) * (ADDR_W+BOX_W)'(SLOTS) + (ADDR_W+BOX_W)'(i);
        return addr_t'(a);
    endfunction

endpackage

// ===== rtl/core/srm_slot_ram.sv =====
module srm_slot_ram (
    input  logic              clk,
    input  srm_pkg::ram_req_t req,
    output srm_pkg::slot_t    rd_data
);

    srm_pkg::slot_t slot_mem [srm_pkg::BOXES * srm_pkg::SLOTS];
    srm_pkg::slot_t rd_data_reg;

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            slot_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= slot_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/srm_ctrl.sv =====
module srm_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  srm_pkg::in_t                  in_data,
    input  logic [srm_pkg::SRC_W-1:0]     hw_source_id,
    output logic                          res_valid,
    input  logic                          res_ready,
    output srm_pkg::out_t                 res_data,
    output srm_pkg::ram_req_t             ram_req,
    input  srm_pkg::slot_t                ram_rd_data
);

    srm_pkg::state_t state_reg, state_next;
    srm_pkg::in_t    cmd_reg, cmd_next;
    srm_pkg::out_t   res_reg, res_next;
    srm_pkg::slot_t  hit_reg, hit_next;
    srm_pkg::idx_t   scan_idx_reg, scan_idx_next;
    srm_pkg::idx_t   chk_idx_reg, chk_idx_next;
    logic            chk_valid_reg, chk_valid_next;
    srm_pkg::idx_t   sh_idx_reg, sh_idx_next;
    logic            sh_pend_reg, sh_pend_next;

    srm_pkg::idx_t   head_reg [srm_pkg::BOXES];
    srm_pkg::idx_t   tail_reg [srm_pkg::BOXES];
    logic            head_inc;
    logic            tail_inc;

    logic                            box_ok;
    logic [srm_pkg::BOX_IDX_W-1:0]   bidx;
    srm_pkg::idx_t                   h;
    srm_pkg::idx_t                   t;
    logic                            match;
    srm_pkg::idx_t                   sh_j;

    // current box pointers
    assign box_ok = int'(cmd_reg.box) < srm_pkg::BOXES;
    assign bidx   = srm_pkg::BOX_IDX_W'(cmd_reg.box);
    assign h      = box_ok ? head_reg[bidx] : '0;
    assign t      = box_ok ? tail_reg[bidx] : '0;
    assign match  = chk_valid_reg
                    && (cmd_reg.any_source || ram_rd_data.src == cmd_reg.source_id);
    assign sh_j   = sh_pend_reg ? srm_pkg::ring_prev(sh_idx_reg) : sh_idx_reg;

    // state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srm_pkg::S_IDLE;
            chk_valid_reg <= 1'b0;
            sh_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            sh_pend_reg   <= sh_pend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        res_reg      <= res_next;
        hit_reg      <= hit_next;
        scan_idx_reg <= scan_idx_next;
        chk_idx_reg  <= chk_idx_next;
        sh_idx_reg   <= sh_idx_next;
    end

    // ring pointers per box
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < srm_pkg::BOXES; b++)
            begin
                head_reg[b] <= '0;
                tail_reg[b] <= '0;
            end
        end
        else
        begin
            if (head_inc)
            begin
                head_reg[bidx] <= srm_pkg::ring_next(h);
            end
            if (tail_inc)
            begin
                tail_reg[bidx] <= srm_pkg::ring_next(t);
            end
        end
    end

    // next state and memory requests
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        hit_next       = hit_reg;
        scan_idx_next  = scan_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = chk_valid_reg;
        sh_idx_next    = sh_idx_reg;
        sh_pend_next   = sh_pend_reg;
        head_inc       = 1'b0;
        tail_inc       = 1'b0;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        ram_req        = '0;

        unique case (state_reg)
            srm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next       = in_data;
                    chk_valid_next = 1'b0;
                    sh_pend_next   = 1'b0;
                    if (int'(in_data.box) < srm_pkg::BOXES)
                        scan_idx_next = head_reg[srm_pkg::BOX_IDX_W'(in_data.box)];
                    else
                        scan_idx_next = '0;
                    if (in_data.func == srm_pkg::FUNC_SEND)
                        state_next = srm_pkg::S_SEND;
                    else
                        state_next = srm_pkg::S_SCAN;
                end
            end

            srm_pkg::S_SEND:
            begin
                res_next = '0;
                if (!box_ok || srm_pkg::ring_next(t) == h)
                begin
                    res_next.status = srm_pkg::ST_FULL;
                end
                else
                begin
                    res_next.status      = srm_pkg::ST_SENT;
                    ram_req.wr_en        = 1'b1;
                    ram_req.wr_addr      = srm_pkg::slot_addr(cmd_reg.box, t);
                    ram_req.wr_data.src  = cmd_reg.from_hw ? hw_source_id : cmd_reg.source_id;
                    ram_req.wr_data.body = srm_pkg::PAYLOAD_BITS'(cmd_reg.payload);
                    tail_inc             = 1'b1;
                end
                state_next = srm_pkg::S_DONE;
            end

            // read ahead one entry while checking the previous one
            srm_pkg::S_SCAN:
            begin
                if (!box_ok)
                begin
                    res_next        = '0;
                    res_next.status = srm_pkg::ST_NONE;
                    state_next      = srm_pkg::S_DONE;
                end
                else if (match)
                begin
                    hit_next       = ram_rd_data;
                    sh_idx_next    = chk_idx_reg;
                    sh_pend_next   = 1'b0;
                    chk_valid_next = 1'b0;
                    state_next     = srm_pkg::S_SHIFT;
                end
                else if (scan_idx_reg == t)
                begin
                    chk_valid_next = 1'b0;
                    if (!chk_valid_reg)
                    begin
                        res_next        = '0;
                        res_next.status = srm_pkg::ST_NONE;
                        state_next      = srm_pkg::S_DONE;
                    end
                end
                else
                begin
                    ram_req.rd_en  = 1'b1;
                    ram_req.rd_addr = srm_pkg::slot_addr(cmd_reg.box, scan_idx_reg);
                    chk_idx_next   = scan_idx_reg;
                    chk_valid_next = 1'b1;
                    scan_idx_next  = srm_pkg::ring_next(scan_idx_reg);
                end
            end

            // move older entries up one slot, one per cycle
            srm_pkg::S_SHIFT:
            begin
                if (sh_pend_reg)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = srm_pkg::slot_addr(cmd_reg.box, sh_idx_reg);
                    ram_req.wr_data = ram_rd_data;
                end
                if (sh_j == h)
                begin
                    head_inc             = 1'b1;
                    sh_pend_next         = 1'b0;
                    res_next.status      = srm_pkg::ST_GOT;
                    res_next.msg_source  = hit_reg.src;
                    res_next.msg_payload = srm_pkg::BODY_W'(hit_reg.body);
                    state_next           = srm_pkg::S_DONE;
                end
                else
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = srm_pkg::slot_addr(cmd_reg.box, srm_pkg::ring_prev(sh_j));
                    sh_idx_next     = sh_j;
                    sh_pend_next    = 1'b1;
                end
            end

            srm_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = srm_pkg::S_IDLE;
            end

            default:
            begin
                state_next = srm_pkg::S_IDLE;
            end
        endcase
    end

    assign res_data = res_reg;

endmodule

// ===== rtl/core/selective_receive_mailbox_top.sv =====
// a send passes S_SEND and S_DONE; a receive passes S_SCAN, reading n entries, then S_SHIFT
// when one matches, moving k entries, and S_DONE; an empty box goes from S_SCAN to S_DONE
// throughput: one transaction at a time, scan and shift walk the slot memory one entry
// per cycle; the next is taken the cycle after the result enters the output register
// reset: all box rings empty, hw_source_id 255, output empty; slot memory not cleared
module selective_receive_mailbox_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  srm_pkg::in_t              in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output srm_pkg::out_t             out_data,
    input  logic                      cfg_wr_en,
    input  logic [srm_pkg::SRC_W-1:0] cfg_wr_data
);

    logic [srm_pkg::SRC_W-1:0] hw_source_id_reg;
    logic                      out_valid_reg;
    srm_pkg::out_t             out_data_reg;

    logic              res_valid;
    logic              res_ready;
    srm_pkg::out_t     res_data;
    srm_pkg::ram_req_t ram_req;
    srm_pkg::slot_t    ram_rd_data;

    // hardware source id register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hw_source_id_reg <= srm_pkg::HW_SOURCE_RESET;
        else if (cfg_wr_en)
            hw_source_id_reg <= cfg_wr_data;
    end

    // output register
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_data_reg <= res_data;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    srm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .hw_source_id (hw_source_id_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_data     (res_data),
        .ram_req      (ram_req),
        .ram_rd_data  (ram_rd_data)
    );

    srm_slot_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

endmodule

// ===== rtl/core/srm_checker.sv =====
module srm_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  srm_pkg::out_t             out_data
);

    // a waiting result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

    // only a received message carries source and body
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != srm_pkg::ST_GOT
        |-> out_data.msg_source == '0 && out_data.msg_payload == '0)
    else $error("non-receive result carries message data");

    // one transaction in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("new transaction taken while busy");

    // a result appears only after the block was busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work");

endmodule

bind selective_receive_mailbox_top srm_checker u_srm_checker (.*);

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srm_pkg::*;

    localparam int CHUNKS     = 4;
    localparam int CHUNK_LEN  = 117;
    localparam int SETTLE_CYC = 2 * SLOTS + 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;
    logic cfg_wr_en = 1'b0;
    logic [SRC_W-1:0] cfg_wr_data = '0;

    // requests waiting for the driver, replies waiting for the dut
    in_t mbox_requests[$];
    out_t predicted_replies[$];

    // shadow copy of the mailbox bank
    slot_t box_mem[BOXES*SLOTS];
    int box_head[BOXES];
    int box_tail[BOXES];
    logic [SRC_W-1:0] hw_id_shadow = HW_SOURCE_RESET;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit in_taken = 1'b0;
    int errors = 0;
    int n_stored = 0;
    int n_refused = 0;
    int n_got = 0;
    int n_miss = 0;

    selective_receive_mailbox_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        foreach (box_head[b])
        begin
            box_head[b] = 0;
            box_tail[b] = 0;
        end
    end

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $time, what);
        errors++;
    endtask

    // apply one transaction to the shadow bank and return the reply it causes
    function automatic out_t mailbox_reply(in_t req);
        out_t res;
        slot_t hit;
        int b;
        int h;
        int t;
        int nt;
        int i;
        int j;
        int p;
        bit found;
        res = '0;
        res.status = ST_SENT;
        b = int'(req.box);
        found = 1'b0;
        if (req.func == FUNC_SEND)
        begin
            if (b >= BOXES)
                res.status = ST_FULL;
            else
            begin
                t = box_tail[b];
                nt = (t + 1) % SLOTS;
                if (nt == box_head[b])
                    res.status = ST_FULL;
                else
                begin
                    box_mem[b*SLOTS + t].src  = req.from_hw ? hw_id_shadow : req.source_id;
                    box_mem[b*SLOTS + t].body = req.payload[PAYLOAD_BITS-1:0];
                    box_tail[b] = nt;
                    res.status = ST_SENT;
                end
            end
        end
        else
        begin
            res.status = ST_NONE;
            if (b < BOXES)
            begin
                h = box_head[b];
                t = box_tail[b];
                i = h;
                while (i != t && !found)
                begin
                    if (req.any_source || box_mem[b*SLOTS + i].src == req.source_id)
                        found = 1'b1;
                    else
                        i = (i + 1) % SLOTS;
                end
                if (found)
                begin
                    hit = box_mem[b*SLOTS + i];
                    // close the gap so older messages keep their order
                    j = i;
                    while (j != h)
                    begin
                        p = (j + SLOTS - 1) % SLOTS;
                        box_mem[b*SLOTS + j] = box_mem[b*SLOTS + p];
                        j = p;
                    end
                    box_head[b] = (h + 1) % SLOTS;
                    res.status = ST_GOT;
                    res.msg_source = hit.src;
                    res.msg_payload = BODY_W'(hit.body);
                end
            end
        end
        return res;
    endfunction

    function automatic in_t make_req(logic func, int box, logic [SRC_W-1:0] src,
                                     logic any, logic hw, logic [BODY_W-1:0] body);
        in_t r;
        r.func = func;
        r.box = BOX_W'(box);
        r.source_id = src;
        r.any_source = any;
        r.from_hw = hw;
        r.payload = body;
        return r;
    endfunction

    // mostly a small pool of ids so selective receives find matches
    function automatic logic [SRC_W-1:0] pick_source();
        logic [SRC_W-1:0] s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: s = SRC_W'($urandom_range(0, 3));
            6: s = 8'hFF;
            7: s = hw_id_shadow;
            default: s = SRC_W'($urandom_range(0, 255));
        endcase
        return s;
    endfunction

    function automatic in_t random_req(int send_pct);
        in_t r;
        int box;
        if ($urandom_range(0, 99) < 70)
            box = $urandom_range(0, 2);
        else
            box = $urandom_range(0, BOXES - 1);
        r = make_req(($urandom_range(0, 99) < send_pct) ? FUNC_SEND : FUNC_RECV, box,
                     pick_source(), ($urandom_range(0, 3) == 0),
                     ($urandom_range(0, 4) == 0), $urandom());
        return r;
    endfunction

    // driver: present requests at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (mbox_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= mbox_requests.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: check replies and predict accepted requests at the rising edge
    always @(posedge clk)
    begin
        out_t exp_r;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected reply status=%0d", out_data.status));
                end
                else
                begin
                    exp_r = predicted_replies.pop_front();
                    case (exp_r.status)
                        ST_SENT: n_stored++;
                        ST_FULL: n_refused++;
                        ST_GOT:  n_got++;
                        default: n_miss++;
                    endcase
                    if (out_data.status !== exp_r.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  out_data.status, exp_r.status));
                    if (out_data.msg_source !== exp_r.msg_source)
                        report_mismatch($sformatf("msg_source got %h want %h",
                                                  out_data.msg_source, exp_r.msg_source));
                    if (out_data.msg_payload !== exp_r.msg_payload)
                        report_mismatch($sformatf("msg_payload got %h want %h",
                                                  out_data.msg_payload, exp_r.msg_payload));
                end
            end
            if (in_valid && in_ready)
                predicted_replies.push_back(mailbox_reply(in_data));
            in_taken = in_valid && in_ready;
        end
    end

    // wait until every request has gone in and every reply has come back
    task automatic drain_all();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (!(mbox_requests.size() == 0 && !in_valid && predicted_replies.size() == 0));
    endtask

    task automatic write_hw_id(logic [SRC_W-1:0] v);
        drain_all();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        hw_id_shadow = v;
    endtask

    initial
    begin
        int send_mix[CHUNKS];
        int ph;
        int c;
        int k;
        send_mix = '{75, 45, 30, 55};
        send_idle_pct = 19;
        recv_idle_pct = 67;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty box, extremes, hw stamping, selective and any receive
        mbox_requests.push_back(make_req(FUNC_RECV, 0, 8'h00, 1'b1, 1'b0, 32'h0));
        mbox_requests.push_back(make_req(FUNC_SEND, 7, 8'h00, 1'b0, 1'b0, 32'h0000_0000));
        mbox_requests.push_back(make_req(FUNC_SEND, 7, 8'hFF, 1'b1, 1'b0, 32'hFFFF_FFFF));
        mbox_requests.push_back(make_req(FUNC_SEND, 7, 8'h12, 1'b0, 1'b1, 32'hA5A5_A5A5));
        mbox_requests.push_back(make_req(FUNC_SEND, 7, 8'h34, 1'b0, 1'b0, 32'h1234_5678));
        // match at the newest entry, the whole ring shifts
        mbox_requests.push_back(make_req(FUNC_RECV, 7, 8'h34, 1'b0, 1'b0, 32'h0));
        mbox_requests.push_back(make_req(FUNC_RECV, 7, 8'h55, 1'b0, 1'b0, 32'h0));
        mbox_requests.push_back(make_req(FUNC_RECV, 7, 8'hFF, 1'b0, 1'b0, 32'h0));
        mbox_requests.push_back(make_req(FUNC_RECV, 7, 8'h99, 1'b1, 1'b1, 32'hDEAD_BEEF));
        mbox_requests.push_back(make_req(FUNC_RECV, 7, 8'h00, 1'b1, 1'b0, 32'h0));
        // fill one box to capacity, then one more send is refused
        for (k = 0; k < SLOTS; k++)
            mbox_requests.push_back(make_req(FUNC_SEND, 3, SRC_W'(k), 1'b0, 1'b0, $urandom()));
        drain_all();

        // random phases, each with its own hw id and idle pattern
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: write_hw_id(8'h00);
                1: write_hw_id(SRC_W'($urandom_range(1, 254)));
                default: write_hw_id(8'hFF);
            endcase
            send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 67 : 0;
            recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 19 : 0;
            for (c = 0; c < CHUNKS; c++)
            begin
                for (k = 0; k < CHUNK_LEN; k++)
                    mbox_requests.push_back(random_req(send_mix[c]));
                // hold off the sender until the bank has answered everything
                drain_all();
            end
        end

        repeat (SETTLE_CYC) @(posedge clk);
        $display("coverage: %0d sends stored, %0d sends refused on a full box", n_stored, n_refused);
        $display("coverage: %0d messages received, %0d receives with no match", n_got, n_miss);
        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
